/* sv/cfdl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfdl_pkg: shared definitions for the CRC framed display link
// Constants, request codes, sequencer states and the structures that pass
// between the sequencer and the shared CRC unit.
// ============================================================================
package cfdl_pkg;

    localparam int          SETTINGS_BYTES_DEF = 16;

    localparam logic [15:0] CRC_POLY           = 16'hA001;
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [7:0]  SYNC_BYTE          = 8'hFA;
    localparam logic [7:0]  CMD_CLEAR_CHANGE   = 8'h03;
    localparam logic [7:0]  CMD_CLEAR_SAVE     = 8'h04;
    localparam logic [7:0]  CMD_WRITE          = 8'h10;
    localparam logic [7:0]  TIMEOUT_RESET      = 8'd100;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2,
        REQ_IDLE = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX_FOLD,
        S_RX_DONE,
        S_READ_WAIT,
        S_TICK_SEL,
        S_TICK_RAM,
        S_TICK_FOLD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        CRC_HOLD,
        CRC_LOAD,
        CRC_XOR,
        CRC_SHIFT
    } crc_op_t;

    typedef struct packed {
        crc_op_t     op;
        logic [15:0] data;
    } crc_ctrl_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       result_last;
        logic       frame_done;
        logic       crc_ok;
        logic [7:0] command_seen;
        logic       clear_change;
        logic       clear_save;
        logic       settings_written;
        logic       link_error;
        logic [7:0] read_data;
    } out_item_t;

endpackage

`default_nettype wire

/* sv/crc_framed_display_link.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crc_framed_display_link: CRC-16/Modbus framed display link
// Receives frame bytes, checks and acts on frames, ages the link timeout
// and sends status frames built from the settings store.
// ============================================================================
// One transaction is taken at a time. A received byte is folded into the
// CRC by the bit-serial CRC unit, one bit per cycle, before its result is
// offered. A tick with a change or save pending yields SETTINGS_BYTES + 5
// results; each header and settings byte is folded into the CRC before it
// is offered, a settings byte after its RAM read, and the two CRC bytes are
// sent unfolded. A read waits on the RAM read data. Every result waits in an
// output register until it is taken. The settings store and the receive stage
// share one RAM as two banks; a committed write frame swaps the banks, so no
// copy pass is needed and the store reads as zero until the first commit.
// ============================================================================
module crc_framed_display_link #(
    parameter int SETTINGS_BYTES = cfdl_pkg::SETTINGS_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic       change_pending,
    input  logic       save_pending,
    input  logic [3:0] read_index,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       tx_valid,
    output logic       result_last,
    output logic       frame_done,
    output logic       crc_ok,
    output logic [7:0] command_seen,
    output logic       clear_change,
    output logic       clear_save,
    output logic       settings_written,
    output logic       link_error,
    output logic [7:0] read_data
);

    import cfdl_pkg::*;

    localparam int IDX_W     = (SETTINGS_BYTES > 1) ? $clog2(SETTINGS_BYTES) : 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int K_W       = $clog2(SETTINGS_BYTES + 5);

    state_t          state_reg, state_next;
    logic [2:0]      step_reg, step_next;
    logic [K_W-1:0]  k_reg, k_next;
    logic [7:0]      ticks_reg, ticks_next;
    logic [7:0]      tcount_reg, tcount_next;
    logic            error_reg, error_next;
    logic [15:0]     rx_crc_reg, rx_crc_next;
    logic [7:0]      rx_count_reg, rx_count_next;
    logic [7:0]      rx_cmd_reg, rx_cmd_next;
    logic            bank_reg, bank_next;
    logic            stored_reg, stored_next;

    logic            chg_reg, chg_next;
    logic            sav_reg, sav_next;
    logic            end_reg, end_next;
    logic            in_range_reg, in_range_next;
    out_item_t       res_reg, res_next;

    crc_ctrl_t       crc_ctrl;
    logic [15:0]     crc;
    logic            ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]      ram_rdata;
    logic [7:0]      ram_byte;

    logic            accept;
    logic            stage_hit;
    logic            k_is_data;
    logic            k_folds;
    logic            k_last;
    logic [7:0]      sel_byte;
    logic            frame_ok;
    logic            tick_busy;

    assign accept    = in_valid && in_ready;
    assign stage_hit = (32'(rx_count_reg) >= 3) && (32'(rx_count_reg) < SETTINGS_BYTES + 3);
    assign k_is_data = (32'(k_reg) >= 3) && (32'(k_reg) < SETTINGS_BYTES + 3);
    assign k_folds   = 32'(k_reg) < SETTINGS_BYTES + 3;
    assign k_last    = 32'(k_reg) == SETTINGS_BYTES + 4;
    assign ram_byte  = stored_reg ? ram_rdata : 8'h00;
    assign frame_ok  = (crc == 16'h0000);
    assign tick_busy = change_pending || save_pending;

    always_comb
    begin
        if (32'(k_reg) == 0)
        begin
            sel_byte = SYNC_BYTE;
        end
        else if (32'(k_reg) == 1)
        begin
            sel_byte = sav_reg ? CMD_CLEAR_SAVE : CMD_CLEAR_CHANGE;
        end
        else if (32'(k_reg) == 2)
        begin
            sel_byte = 8'(SETTINGS_BYTES);
        end
        else if (32'(k_reg) == SETTINGS_BYTES + 3)
        begin
            sel_byte = crc[7:0];
        end
        else
        begin
            sel_byte = crc[15:8];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_t'(req_type))
                        REQ_BYTE: state_next = S_RX_FOLD;
                        REQ_TICK: state_next = tick_busy ? S_TICK_SEL : S_OUT;
                        REQ_READ: state_next = S_READ_WAIT;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_RX_FOLD:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = S_RX_DONE;
                end
            end
            S_RX_DONE:   state_next = S_OUT;
            S_READ_WAIT: state_next = S_OUT;
            S_TICK_SEL:
            begin
                if (k_is_data)
                begin
                    state_next = S_TICK_RAM;
                end
                else if (k_folds)
                begin
                    state_next = S_TICK_FOLD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_TICK_RAM:  state_next = S_TICK_FOLD;
            S_TICK_FOLD:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = res_reg.result_last ? S_IDLE : S_TICK_SEL;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, CRC unit commands and RAM ports.
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        out_valid     = (state_reg == S_OUT);
        crc_ctrl.op   = CRC_HOLD;
        crc_ctrl.data = 16'h0000;
        ram_we        = 1'b0;
        ram_waddr     = {~bank_reg, IDX_W'(rx_count_reg - 8'd3)};
        ram_raddr     = {bank_reg, IDX_W'(read_index)};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_t'(req_type))
                        REQ_BYTE:
                        begin
                            crc_ctrl.op   = CRC_LOAD;
                            crc_ctrl.data = rx_crc_reg ^ {8'h00, rx_byte};
                            ram_we        = stage_hit;
                        end
                        REQ_TICK:
                        begin
                            crc_ctrl.op   = CRC_LOAD;
                            crc_ctrl.data = CRC_INIT;
                        end
                        default:
                        begin
                            crc_ctrl.op   = CRC_HOLD;
                        end
                    endcase
                end
            end
            S_RX_FOLD, S_TICK_FOLD:
            begin
                crc_ctrl.op = CRC_SHIFT;
            end
            S_TICK_SEL:
            begin
                ram_raddr = {bank_reg, IDX_W'(k_reg - K_W'(3))};
                if (!k_is_data && k_folds)
                begin
                    crc_ctrl.op   = CRC_XOR;
                    crc_ctrl.data = {8'h00, sel_byte};
                end
            end
            S_TICK_RAM:
            begin
                crc_ctrl.op   = CRC_XOR;
                crc_ctrl.data = {8'h00, ram_byte};
            end
            default:
            begin
                crc_ctrl.op = CRC_HOLD;
            end
        endcase
    end

    // Datapath and link state.
    always_comb
    begin
        step_next     = step_reg;
        k_next        = k_reg;
        ticks_next    = ticks_reg;
        tcount_next   = tcount_reg;
        error_next    = error_reg;
        rx_crc_next   = rx_crc_reg;
        rx_count_next = rx_count_reg;
        rx_cmd_next   = rx_cmd_reg;
        bank_next     = bank_reg;
        stored_next   = stored_reg;
        chg_next      = chg_reg;
        sav_next      = sav_reg;
        end_next      = end_reg;
        in_range_next = in_range_reg;
        res_next      = res_reg;

        if (cfg_valid && cfg_ready)
        begin
            ticks_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    chg_next      = change_pending;
                    sav_next      = save_pending;
                    end_next      = frame_end;
                    in_range_next = 32'(read_index) < SETTINGS_BYTES;
                    step_next     = 3'd0;
                    k_next        = '0;
                    res_next             = '0;
                    res_next.result_last = 1'b1;
                    res_next.link_error  = error_reg;
                    case (req_t'(req_type))
                        REQ_BYTE:
                        begin
                            if (rx_count_reg == 8'd1)
                            begin
                                rx_cmd_next = rx_byte;
                            end
                            if (rx_count_reg != 8'hFF)
                            begin
                                rx_count_next = rx_count_reg + 8'd1;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (tcount_reg < ticks_reg)
                            begin
                                tcount_next = tcount_reg + 8'd1;
                            end
                            else
                            begin
                                error_next          = 1'b1;
                                res_next.link_error = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next.result_last = 1'b1;
                        end
                    endcase
                end
            end
            S_RX_FOLD, S_TICK_FOLD:
            begin
                step_next = step_reg + 3'd1;
            end
            S_RX_DONE:
            begin
                if (end_reg)
                begin
                    res_next.frame_done   = 1'b1;
                    res_next.crc_ok       = frame_ok;
                    res_next.command_seen = rx_cmd_reg;
                    rx_crc_next   = CRC_INIT;
                    rx_count_next = 8'd0;
                    rx_cmd_next   = 8'd0;
                    if (frame_ok)
                    begin
                        tcount_next         = 8'd0;
                        error_next          = 1'b0;
                        res_next.link_error = 1'b0;
                        if (rx_cmd_reg == CMD_CLEAR_CHANGE)
                        begin
                            res_next.clear_change = 1'b1;
                        end
                        else if (rx_cmd_reg == CMD_CLEAR_SAVE)
                        begin
                            res_next.clear_save = 1'b1;
                        end
                        else if ((rx_cmd_reg == CMD_WRITE) && !chg_reg && !sav_reg
                                 && (32'(rx_count_reg) >= SETTINGS_BYTES + 5))
                        begin
                            bank_next                 = ~bank_reg;
                            stored_next               = 1'b1;
                            res_next.settings_written = 1'b1;
                        end
                    end
                end
                else
                begin
                    rx_crc_next = crc;
                end
            end
            S_READ_WAIT:
            begin
                res_next.read_data = in_range_reg ? ram_byte : 8'h00;
            end
            S_TICK_SEL:
            begin
                step_next            = 3'd0;
                res_next             = '0;
                res_next.tx_byte     = sel_byte;
                res_next.tx_valid    = 1'b1;
                res_next.result_last = k_last;
                res_next.link_error  = error_reg;
            end
            S_TICK_RAM:
            begin
                res_next.tx_byte = ram_byte;
            end
            S_OUT:
            begin
                if (out_ready && !res_reg.result_last)
                begin
                    k_next = k_reg + K_W'(1);
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= 3'd0;
            k_reg        <= '0;
            ticks_reg    <= TIMEOUT_RESET;
            tcount_reg   <= 8'd0;
            error_reg    <= 1'b0;
            rx_crc_reg   <= CRC_INIT;
            rx_count_reg <= 8'd0;
            rx_cmd_reg   <= 8'd0;
            bank_reg     <= 1'b0;
            stored_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            k_reg        <= k_next;
            ticks_reg    <= ticks_next;
            tcount_reg   <= tcount_next;
            error_reg    <= error_next;
            rx_crc_reg   <= rx_crc_next;
            rx_count_reg <= rx_count_next;
            rx_cmd_reg   <= rx_cmd_next;
            bank_reg     <= bank_next;
            stored_reg   <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chg_reg      <= chg_next;
        sav_reg      <= sav_next;
        end_reg      <= end_next;
        in_range_reg <= in_range_next;
        res_reg      <= res_next;
    end

    cfdl_crc_unit u_crc (
        .clk  (clk),
        .ctrl (crc_ctrl),
        .crc  (crc)
    );

    cfdl_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready        = 1'b1;
    assign tx_byte          = res_reg.tx_byte;
    assign tx_valid         = res_reg.tx_valid;
    assign result_last      = res_reg.result_last;
    assign frame_done       = res_reg.frame_done;
    assign crc_ok           = res_reg.crc_ok;
    assign command_seen     = res_reg.command_seen;
    assign clear_change     = res_reg.clear_change;
    assign clear_save       = res_reg.clear_save;
    assign settings_written = res_reg.settings_written;
    assign link_error       = res_reg.link_error;
    assign read_data        = res_reg.read_data;

endmodule

`default_nettype wire

/* sv/cfdl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfdl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module cfdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/cfdl_crc_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cfdl_crc_unit: bit-serial CRC-16/Modbus unit
// Holds one working CRC value and applies a load, a byte XOR or one
// reflected shift step per cycle, as the sequencer commands.
// ============================================================================
module cfdl_crc_unit (
    input  logic                 clk,
    input  cfdl_pkg::crc_ctrl_t  ctrl,
    output logic [15:0]          crc
);

    import cfdl_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        case (ctrl.op)
            CRC_LOAD:  crc_next = ctrl.data;
            CRC_XOR:   crc_next = crc_reg ^ ctrl.data;
            CRC_SHIFT: crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            default:   crc_next = crc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire
